// ===== hdl/wsd_pkg.sv =====
// shared types and constants for the websocket frame deframer
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  localparam logic [6:0] LEN_EXT16 = 7'h7e;
  localparam logic [6:0] LEN_EXT64 = 7'h7f;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES = 3'd4;
  localparam logic [63:0] LEN_ONE = 64'h1;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        fin_bit;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [63:0] decoded_len;
    logic        last_of_frame;
  } res_t;

endpackage

// ===== hdl/wsd_parser.sv =====
// frame header parser, key capture and payload unmasking, one byte per cycle while step_i is high
module wsd_parser import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q, hdr_d;
  logic        mask_q, mask_d;
  logic [3:0]  ext_q, ext_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  kleft_q, kleft_d;
  logic [63:0] rem_q, rem_d;
  logic [1:0]  kpos_q, kpos_d;

  logic        len_done;
  logic        start_pl;
  logic [7:0]  key_byte;

  always_comb begin
    phase_d     = phase_q;
    hdr_d       = hdr_q;
    mask_d      = mask_q;
    ext_d       = ext_q;
    len_d       = len_q;
    key_d       = key_q;
    kleft_d     = kleft_q;
    rem_d       = rem_q;
    kpos_d      = kpos_q;
    len_done    = 1'b0;
    start_pl    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    key_byte    = key_q[31:24];

    unique case (phase_q)
      PH_HDR1: begin
        mask_d = byte_i[7];
        key_d  = '0;
        len_d  = '0;
        if (byte_i[6:0] == LEN_EXT16) begin
          ext_d   = EXT16_BYTES;
          phase_d = PH_EXT;
        end else if (byte_i[6:0] == LEN_EXT64) begin
          ext_d   = EXT64_BYTES;
          phase_d = PH_EXT;
        end else begin
          len_d    = {57'd0, byte_i[6:0]};
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        len_d = {len_q[55:0], byte_i};
        ext_d = ext_q - 4'd1;
        if (ext_d == 4'd0) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_d   = {key_q[23:0], byte_i};
        kleft_d = kleft_q - 3'd1;
        if (kleft_d == 3'd0) begin
          start_pl = 1'b1;
        end
      end
      PH_DATA: begin
        case (kpos_q)
          2'd0:    key_byte = key_q[31:24];
          2'd1:    key_byte = key_q[23:16];
          2'd2:    key_byte = key_q[15:8];
          default: key_byte = key_q[7:0];
        endcase
        kpos_d = kpos_q + 2'd1;
        rem_d  = rem_q - LEN_ONE;
        res_valid_o         = 1'b1;
        res_o.payload_byte  = byte_i ^ key_byte;
        res_o.byte_valid    = 1'b1;
        res_o.last_of_frame = (rem_q == LEN_ONE);
        if (rem_q == LEN_ONE) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        // unused phase codes act as the first header byte
        hdr_d   = byte_i;
        phase_d = PH_HDR1;
      end
    endcase

    if (len_done) begin
      if (mask_d) begin
        kleft_d = KEY_BYTES;
        phase_d = PH_KEY;
      end else begin
        start_pl = 1'b1;
      end
    end

    if (start_pl) begin
      kpos_d = '0;
      if (len_d == 64'd0) begin
        // empty payload gives one header-only item
        rem_d               = '0;
        phase_d             = PH_HDR0;
        res_valid_o         = 1'b1;
        res_o.last_of_frame = 1'b1;
      end else begin
        rem_d   = len_d;
        phase_d = PH_DATA;
      end
    end

    res_o.fin_bit        = hdr_q[7];
    res_o.reserved_bits  = hdr_q[6:4];
    res_o.frame_opcode   = hdr_q[3:0];
    res_o.was_masked     = mask_d;
    res_o.decoded_len    = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      hdr_q   <= '0;
      mask_q  <= 1'b0;
      ext_q   <= '0;
      len_q   <= '0;
      key_q   <= '0;
      kleft_q <= '0;
      rem_q   <= '0;
      kpos_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      mask_q  <= mask_d;
      ext_q   <= ext_d;
      len_q   <= len_d;
      key_q   <= key_d;
      kleft_q <= kleft_d;
      rem_q   <= rem_d;
      kpos_q  <= kpos_d;
    end
  end

endmodule

// ===== hdl/wsd_out_reg.sv =====
// result register holding one item until the consumer takes it
module wsd_out_reg import wsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  res_t wr_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  logic out_v_q;
  res_t out_q;

  assign wr_ready_o  = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (wr_ready_o) begin
      out_v_q <= wr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i && wr_ready_o) begin
      out_q <= wr_data_i;
    end
  end

endmodule

// ===== hdl/websocket_frame_deframer_unit.sv =====
// top level of the websocket frame deframer
// each byte is held in the input register, its result in the result register
// throughput: one byte per cycle, limited only by the output handshake
// bytes that produce no result never wait for the result register
// reset: asynchronous, active low; parser returns to awaiting header byte 0
module websocket_frame_deframer_unit import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic        fin_bit_o,
  output logic [2:0]  reserved_bits_o,
  output logic [3:0]  frame_opcode_o,
  output logic        was_masked_o,
  output logic [63:0] decoded_len_o,
  output logic        last_of_frame_o
);

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       res_valid;
  res_t       res;
  logic       buf_ready;
  res_t       out_res;

  // input item moves on unless it has a result and the result slot is full
  assign step       = in_v_q && (!res_valid || buf_ready);
  assign in_ready_o = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_valid_i  (step && res_valid),
    .wr_ready_o  (buf_ready),
    .wr_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign payload_byte_o   = out_res.payload_byte;
  assign byte_valid_o     = out_res.byte_valid;
  assign fin_bit_o        = out_res.fin_bit;
  assign reserved_bits_o  = out_res.reserved_bits;
  assign frame_opcode_o   = out_res.frame_opcode;
  assign was_masked_o     = out_res.was_masked;
  assign decoded_len_o    = out_res.decoded_len;
  assign last_of_frame_o  = out_res.last_of_frame;

endmodule

// ===== test/websocket_frame_deframer_unit_tb.sv =====
// testbench for the websocket frame deframer: directed and random frame streams checked by a parser model
module websocket_frame_deframer_unit_tb;
  import wsd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  payload_byte_o;
  logic        byte_valid_o;
  logic        fin_bit_o;
  logic [2:0]  reserved_bits_o;
  logic [3:0]  frame_opcode_o;
  logic        was_masked_o;
  logic [63:0] decoded_len_o;
  logic        last_of_frame_o;

  websocket_frame_deframer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .byte_valid_o    (byte_valid_o),
    .fin_bit_o       (fin_bit_o),
    .reserved_bits_o (reserved_bits_o),
    .frame_opcode_o  (frame_opcode_o),
    .was_masked_o    (was_masked_o),
    .decoded_len_o   (decoded_len_o),
    .last_of_frame_o (last_of_frame_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // parser model state
  phase_e      parse_st;
  logic [7:0]  hdr_byte0;
  logic        frame_masked;
  logic [3:0]  ext_left;
  logic [63:0] frame_len;
  logic [31:0] key_word;
  logic [2:0]  key_left;
  logic [63:0] bytes_left;
  logic [1:0]  key_idx;

  res_t expected_results[$];
  int   mismatches;
  int   bytes_sent;
  int   stuck_cycles;
  bit   idle_on;
  bit   hold_request;

  function automatic void queue_result(logic [7:0] b, logic valid, logic last);
    res_t r;
    r.payload_byte   = b;
    r.byte_valid     = valid;
    r.fin_bit        = hdr_byte0[7];
    r.reserved_bits  = hdr_byte0[6:4];
    r.frame_opcode   = hdr_byte0[3:0];
    r.was_masked     = frame_masked;
    r.decoded_len    = frame_len;
    r.last_of_frame  = last;
    expected_results.push_back(r);
  endfunction

  function automatic void start_payload();
    key_idx = '0;
    if (frame_len == '0) begin
      bytes_left = '0;
      parse_st = PH_HDR0;
      queue_result(8'h00, 1'b0, 1'b1);
    end else begin
      bytes_left = frame_len;
      parse_st = PH_DATA;
    end
  endfunction

  function automatic void finish_length();
    if (frame_masked) begin
      key_left = KEY_BYTES;
      parse_st = PH_KEY;
    end else begin
      start_payload();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] kb;
    case (parse_st)
      PH_HDR1: begin
        frame_masked = b[7];
        key_word = '0;
        frame_len = '0;
        if (b[6:0] == LEN_EXT16) begin
          ext_left = EXT16_BYTES;
          parse_st = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left = EXT64_BYTES;
          parse_st = PH_EXT;
        end else begin
          frame_len = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PH_EXT: begin
        frame_len = {frame_len[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == '0) finish_length();
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        key_left = key_left - 3'd1;
        if (key_left == '0) start_payload();
      end
      PH_DATA: begin
        kb = key_word[8 * (3 - int'(key_idx)) +: 8];
        key_idx = key_idx + 2'd1;
        bytes_left = bytes_left - LEN_ONE;
        if (bytes_left == '0) begin
          parse_st = PH_HDR0;
          queue_result(b ^ kb, 1'b1, 1'b1);
        end else begin
          queue_result(b ^ kb, 1'b1, 1'b0);
        end
      end
      default: begin
        hdr_byte0 = b;
        parse_st = PH_HDR1;
      end
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  // valid stays high across back-to-back items, dropped only for a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic push_frame(input logic [7:0] h0, input logic mask, input logic [6:0] code,
                            input logic [63:0] len, input int body);
    int i;
    send_byte(h0);
    send_byte({mask, code});
    if (code == LEN_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (code == LEN_EXT64) begin
      for (i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    if (mask) repeat (4) send_byte(8'($urandom));
    for (i = 0; i < body; i++) send_byte(8'($urandom));
  endtask

  task automatic random_frame();
    logic [63:0] len;
    logic [6:0]  code;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 15) len = 64'd0;
    else if (r < 80) len = 64'($urandom_range(1, 16));
    else if (r < 95) len = 64'($urandom_range(17, 125));
    else len = 64'($urandom_range(126, 300));
    r = $urandom_range(0, 9);
    // short lengths sometimes go out in a longer encoding than needed
    if (len >= 64'd126) code = (r < 5) ? LEN_EXT16 : LEN_EXT64;
    else if (r < 2) code = LEN_EXT16;
    else if (r < 4) code = LEN_EXT64;
    else code = len[6:0];
    push_frame(8'($urandom), 1'($urandom_range(0, 1)), code, len, int'(len));
  endtask

  task automatic test_directed();
    idle_on = 1'b0;
    // empty frame, all header bits clear
    push_frame(8'h00, 1'b0, 7'd0, 64'd0, 0);
    // masked five-byte frame whose payload bytes alternate 00 and ff before a final 5a
    push_frame(8'hff, 1'b1, 7'd5, 64'd5, 0);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h5a);
    // 16-bit length code carrying zero
    push_frame(8'h8a, 1'b0, LEN_EXT16, 64'd0, 0);
    // 64-bit length code carrying a tiny length
    push_frame(8'h72, 1'b0, LEN_EXT64, 64'd2, 2);
  endtask

  task automatic test_random_frames(input int upto);
    idle_on = 1'b1;
    while (bytes_sent < upto) random_frame();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (12) random_frame();
  endtask

  task automatic test_output_hold();
    int start;
    idle_on = 1'b0;
    hold_request = 1'b1;
    start = bytes_sent;
    while (bytes_sent < start + 250) push_frame(8'($urandom), 1'b1, 7'd20, 64'd20, 20);
    idle_on = 1'b1;
  endtask

  // top length bit set: never ends, so it has to be the last frame of the run
  task automatic test_huge_length();
    idle_on = 1'b1;
    push_frame(8'h81, 1'b1, LEN_EXT64, 64'hffff_ffff_ffff_fff7, 24);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // outputs are registered, so both sides are stable at the falling edge
  always @(negedge clk_i) begin
    res_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, payload_byte %0h last %0b", $time,
                 payload_byte_o, last_of_frame_o);
      end else begin
        want = expected_results.pop_front();
        check_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte_o));
        check_field("byte_valid", 64'(want.byte_valid), 64'(byte_valid_o));
        check_field("fin_bit", 64'(want.fin_bit), 64'(fin_bit_o));
        check_field("reserved_bits", 64'(want.reserved_bits), 64'(reserved_bits_o));
        check_field("frame_opcode", 64'(want.frame_opcode), 64'(frame_opcode_o));
        check_field("was_masked", 64'(want.was_masked), 64'(was_masked_o));
        check_field("decoded_len", want.decoded_len, decoded_len_o);
        check_field("last_of_frame", 64'(want.last_of_frame), 64'(last_of_frame_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    idle_on      = 1'b0;
    hold_request = 1'b0;
    mismatches   = 0;
    bytes_sent   = 0;
    stuck_cycles = 0;
    parse_st     = PH_HDR0;
    hdr_byte0    = '0;
    frame_masked = 1'b0;
    ext_left     = '0;
    frame_len    = '0;
    key_word     = '0;
    key_left     = '0;
    bytes_left   = '0;
    key_idx      = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_frames(500);
    test_back_to_back();
    test_output_hold();
    test_random_frames(1250);
    test_huge_length();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
